// ===== src/kmcl_pkg.sv =====
package kmcl_pkg;

    // Default geometry of the matrix and the layer stack.
    localparam int ROWS_PER_COLUMN = 9;
    localparam int COLUMN_COUNT    = 7;
    localparam int LAYER_COUNT     = 4;

    // Fixed field widths.
    localparam int MAP_KEYS     = 63;
    localparam int KEY_W        = 6;
    localparam int COLUMN_W     = 3;
    localparam int ROW_BITS_W   = 9;
    localparam int MAP_ADDR_W   = 8;
    localparam int CODE_W       = 8;
    localparam int KEYMAP_DEPTH = 256;
    localparam int LAYER_W      = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 6;

    localparam logic [KEY_W-1:0] RESET_LAYER_KEY    = 6'd4;
    localparam logic [KEY_W-1:0] RESET_LOCK_ONE_KEY = 6'd60;
    localparam logic [KEY_W-1:0] RESET_LOCK_TWO_KEY = 6'd61;

    typedef enum logic {
        OP_SCAN      = 1'b0,
        OP_MAP_WRITE = 1'b1
    } t_op;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LAYER_KEY    = 2'd0,
        CFG_LOCK_ONE_KEY = 2'd1,
        CFG_LOCK_TWO_KEY = 2'd2
    } t_cfg_index;

    typedef enum logic [1:0] {
        LOCK_NONE  = 2'd0,
        LOCK_TWO   = 2'd1,
        LOCK_THREE = 2'd2
    } t_lock;

    // A scan beat that changed exactly one key.
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic             down;
    } t_hit;

    typedef struct packed {
        logic              valid;
        logic [CODE_W-1:0] key_byte;
        logic [KEY_W-1:0]  key_index;
        logic              pressed;
    } t_result;

endpackage

// ===== src/kmcl_in_if.sv =====
interface kmcl_in_if;
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [kmcl_pkg::COLUMN_W-1:0]       column;
    logic [kmcl_pkg::ROW_BITS_W-1:0]     row_bits;
    logic [kmcl_pkg::MAP_ADDR_W-1:0]     map_address;
    logic [kmcl_pkg::CODE_W-1:0]         map_data;

    modport source (
        output valid, op, column, row_bits, map_address, map_data,
        input  ready
    );

    modport sink (
        input  valid, op, column, row_bits, map_address, map_data,
        output ready
    );
endinterface

// ===== src/kmcl_out_if.sv =====
interface kmcl_out_if;
    logic                            valid;
    logic                            ready;
    logic [kmcl_pkg::CODE_W-1:0]     key_byte;
    logic [kmcl_pkg::KEY_W-1:0]      key_index;
    logic                            pressed;

    modport source (
        output valid, key_byte, key_index, pressed,
        input  ready
    );

    modport sink (
        input  valid, key_byte, key_index, pressed,
        output ready
    );
endinterface

// ===== src/key_matrix_change_layer_mapper_core.sv =====
// Channel   | Dir | Beat contents
// ----------+-----+----------------------------------------------------------
// i_in      | in  | op, column, row_bits (scan) or map_address, map_data (load)
// o_out     | out | key_byte, key_index, pressed for one changed key
// i_cfg_*   | in  | write of layer_key, lock_one_key or lock_two_key by index
//
// One beat is taken per cycle while the output buffer has room. A scan result
// passes through a keymap read of the base layer, a read at the active layer
// and then the output register. Reset is synchronous and clears the
// pressed-key map and the layer state and restores the default configuration;
// the keymap memory is not cleared and needs no clearing pass.
// Input ready falls only when both output slots hold results, and the whole
// pipeline holds in place while it is low.
module key_matrix_change_layer_mapper_core #(
    parameter int ROWS_PER_COLUMN = kmcl_pkg::ROWS_PER_COLUMN,
    parameter int COLUMN_COUNT    = kmcl_pkg::COLUMN_COUNT,
    parameter int LAYER_COUNT     = kmcl_pkg::LAYER_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    kmcl_in_if.sink                          i_in,
    kmcl_out_if.source                       o_out,
    input  logic                             i_cfg_we,
    input  logic [kmcl_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [kmcl_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                            adv;
    logic                            full;
    logic                            accept;
    logic                            scan_en;
    logic                            map_we;
    kmcl_pkg::t_hit                  hit;
    logic [kmcl_pkg::MAP_KEYS-1:0]   pressed_map;
    logic [kmcl_pkg::CODE_W-1:0]     base_code;
    logic [kmcl_pkg::CODE_W-1:0]     layer_code;
    logic [kmcl_pkg::MAP_ADDR_W-1:0] layer_addr;
    kmcl_pkg::t_result               result;

    // The pipeline moves as one: every stage, and the keymap read registers,
    // advance whenever the skid slot of the output buffer is free.
    assign adv        = !full;
    assign i_in.ready = adv;
    assign accept     = i_in.valid && adv;
    assign scan_en    = accept && (i_in.op == kmcl_pkg::OP_SCAN);
    assign map_we     = accept && (i_in.op == kmcl_pkg::OP_MAP_WRITE);

    // Change detection, key number and the pressed-key map.
    kmcl_scan #(
        .ROWS_PER_COLUMN (ROWS_PER_COLUMN),
        .COLUMN_COUNT    (COLUMN_COUNT)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_scan_en     (scan_en),
        .i_column      (i_in.column),
        .i_row_bits    (i_in.row_bits),
        .o_hit         (hit),
        .o_pressed_map (pressed_map)
    );

    // Port A reads the base-layer code of the changed key in the beat's own
    // cycle. Port B reads the active-layer code once the key has moved into
    // r_s1 of the layer stage, after any layer change by the previous key has
    // landed. Both read before a write on the same edge, which keeps a load
    // that follows a scan from leaking into that scan's result.
    kmcl_ram #(
        .WIDTH (kmcl_pkg::CODE_W),
        .DEPTH (kmcl_pkg::KEYMAP_DEPTH)
    ) u_keymap (
        .i_clk     (i_clk),
        .i_we      (map_we),
        .i_waddr   (i_in.map_address),
        .i_wdata   (i_in.map_data),
        .i_re      (adv),
        .i_raddr_a (kmcl_pkg::MAP_ADDR_W'(hit.key)),
        .i_raddr_b (layer_addr),
        .o_rdata_a (base_code),
        .o_rdata_b (layer_code)
    );

    // Layer keys update the layer state here; other keys pick up their code.
    kmcl_layer #(
        .LAYER_COUNT (LAYER_COUNT)
    ) u_layer (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_hit         (hit),
        .i_pressed_map (pressed_map),
        .i_base_code   (base_code),
        .i_code        (layer_code),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_read_addr   (layer_addr),
        .o_result      (result)
    );

    // Two-entry output buffer: the output register and a skid slot.
    kmcl_out_buf u_out_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push_en (adv),
        .i_result  (result),
        .o_full    (full),
        .o_out     (o_out)
    );

endmodule

// ===== src/kmcl_ram.sv =====
module kmcl_ram #(
    parameter int WIDTH = kmcl_pkg::CODE_W,
    parameter int DEPTH = kmcl_pkg::KEYMAP_DEPTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    // Reads return the contents from before a write on the same edge.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ===== src/kmcl_scan.sv =====
module kmcl_scan #(
    parameter int ROWS_PER_COLUMN = kmcl_pkg::ROWS_PER_COLUMN,
    parameter int COLUMN_COUNT    = kmcl_pkg::COLUMN_COUNT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_scan_en,
    input  logic [kmcl_pkg::COLUMN_W-1:0]   i_column,
    input  logic [kmcl_pkg::ROW_BITS_W-1:0] i_row_bits,
    output kmcl_pkg::t_hit                  o_hit,
    output logic [kmcl_pkg::MAP_KEYS-1:0]   o_pressed_map
);

    localparam int ROW_IDX_W = (ROWS_PER_COLUMN > 1) ? $clog2(ROWS_PER_COLUMN) : 1;
    localparam int BASE_W    = $clog2((2 ** kmcl_pkg::COLUMN_W) * ROWS_PER_COLUMN
                                      + ROWS_PER_COLUMN + 1);

    logic [kmcl_pkg::MAP_KEYS-1:0] r_pressed_map;
    logic [kmcl_pkg::MAP_KEYS-1:0] n_pressed_map;
    logic [kmcl_pkg::MAP_KEYS-1:0] shifted;
    logic [BASE_W-1:0]             base;
    logic                          in_range;
    logic [ROWS_PER_COLUMN-1:0]    rows;
    logic [ROWS_PER_COLUMN-1:0]    window;
    logic [ROWS_PER_COLUMN-1:0]    changed;
    logic                          one_change;
    logic [ROW_IDX_W-1:0]          row_idx;

    assign base     = BASE_W'(i_column) * BASE_W'(ROWS_PER_COLUMN);
    assign in_range = ({1'b0, i_column} < (kmcl_pkg::COLUMN_W + 1)'(COLUMN_COUNT))
                   && ((BASE_W + 1)'(base) + (BASE_W + 1)'(ROWS_PER_COLUMN)
                       <= (BASE_W + 1)'(kmcl_pkg::MAP_KEYS));

    assign shifted    = r_pressed_map >> base;
    assign window     = shifted[ROWS_PER_COLUMN-1:0];
    assign rows       = ROWS_PER_COLUMN'(i_row_bits);
    assign changed    = rows ^ window;
    assign one_change = (changed != '0) && ((changed & (changed - 1'b1)) == '0);

    // With a single bit set, OR-ing the indexes of the set bits gives its position.
    always_comb begin
        row_idx = '0;
        for (int r = 0; r < ROWS_PER_COLUMN; r++) begin
            if (changed[r]) begin
                row_idx = row_idx | ROW_IDX_W'(r);
            end
        end
    end

    always_comb begin
        o_hit.valid = i_scan_en && in_range && one_change;
        o_hit.key   = kmcl_pkg::KEY_W'(base + BASE_W'(row_idx));
        o_hit.down  = |(rows & changed);
    end

    always_comb begin
        n_pressed_map = r_pressed_map;
        if (o_hit.valid) begin
            n_pressed_map = r_pressed_map ^ (kmcl_pkg::MAP_KEYS'(1) << o_hit.key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed_map <= '0;
        end else begin
            r_pressed_map <= n_pressed_map;
        end
    end

    assign o_pressed_map = r_pressed_map;

`ifndef NO_ASSERTIONS
    a_hit_flips_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit.valid |=> (r_pressed_map != $past(r_pressed_map)))
        else $error("accepted key change did not update the pressed-key map");
    a_map_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_hit.valid |=> $stable(r_pressed_map))
        else $error("pressed-key map changed without a single-key change");
`endif

endmodule

// ===== src/kmcl_layer.sv =====
module kmcl_layer #(
    parameter int LAYER_COUNT = kmcl_pkg::LAYER_COUNT
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_adv,
    input  kmcl_pkg::t_hit                   i_hit,
    input  logic [kmcl_pkg::MAP_KEYS-1:0]    i_pressed_map,
    input  logic [kmcl_pkg::CODE_W-1:0]      i_base_code,
    input  logic [kmcl_pkg::CODE_W-1:0]      i_code,
    input  logic                             i_cfg_we,
    input  logic [kmcl_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [kmcl_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output logic [kmcl_pkg::MAP_ADDR_W-1:0]  o_read_addr,
    output kmcl_pkg::t_result                o_result
);

    localparam logic [kmcl_pkg::LAYER_W-1:0] TOP_LAYER = kmcl_pkg::LAYER_W'(LAYER_COUNT - 1);

    kmcl_pkg::t_hit                  r_s1;
    kmcl_pkg::t_hit                  r_s2;
    kmcl_pkg::t_hit                  n_s2;
    logic [kmcl_pkg::LAYER_W-1:0]    r_layer;
    logic [kmcl_pkg::LAYER_W-1:0]    n_layer;
    kmcl_pkg::t_lock                 r_lock;
    kmcl_pkg::t_lock                 n_lock;
    logic [kmcl_pkg::KEY_W-1:0]      r_layer_key;
    logic [kmcl_pkg::KEY_W-1:0]      r_lock_one_key;
    logic [kmcl_pkg::KEY_W-1:0]      r_lock_two_key;
    logic [kmcl_pkg::MAP_KEYS:0]     map_ext;
    logic                            layer_down;
    logic                            lock_one_down;
    logic                            lock_two_down;
    logic                            is_layer_key;
    logic [kmcl_pkg::LAYER_W-1:0]    layer_sat;

    // The extra top bit stands for key 63, which is never down.
    assign map_ext       = {1'b0, i_pressed_map};
    assign layer_down    = map_ext[r_layer_key];
    assign lock_one_down = map_ext[r_lock_one_key];
    assign lock_two_down = map_ext[r_lock_two_key];
    assign is_layer_key  = r_s1.valid && i_base_code[kmcl_pkg::CODE_W-1];

    always_comb begin
        n_layer = r_layer;
        n_lock  = r_lock;
        if (i_adv && is_layer_key) begin
            if (layer_down) begin
                n_layer = kmcl_pkg::LAYER_W'(1);
                n_lock  = kmcl_pkg::LOCK_NONE;
                if (lock_one_down) begin
                    n_layer = kmcl_pkg::LAYER_W'(2);
                    n_lock  = kmcl_pkg::LOCK_TWO;
                end else if (lock_two_down) begin
                    n_layer = kmcl_pkg::LAYER_W'(3);
                    n_lock  = kmcl_pkg::LOCK_THREE;
                end
            end else if (r_lock == kmcl_pkg::LOCK_NONE) begin
                n_layer = '0;
            end
        end
    end

    assign layer_sat   = (r_layer > TOP_LAYER) ? TOP_LAYER : r_layer;
    assign o_read_addr = {layer_sat, r_s1.key};

    always_comb begin
        n_s2       = r_s1;
        n_s2.valid = r_s1.valid && !i_base_code[kmcl_pkg::CODE_W-1];
    end

    always_comb begin
        o_result.valid     = r_s2.valid;
        o_result.key_byte  = {i_code[kmcl_pkg::CODE_W-1] ^ r_s2.down,
                              i_code[kmcl_pkg::CODE_W-2:0]};
        o_result.key_index = r_s2.key;
        o_result.pressed   = r_s2.down;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
            r_s2.valid <= 1'b0;
        end else if (i_adv) begin
            r_s1 <= i_hit;
            r_s2 <= n_s2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer <= '0;
            r_lock  <= kmcl_pkg::LOCK_NONE;
        end else begin
            r_layer <= n_layer;
            r_lock  <= n_lock;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_layer_key    <= kmcl_pkg::RESET_LAYER_KEY;
            r_lock_one_key <= kmcl_pkg::RESET_LOCK_ONE_KEY;
            r_lock_two_key <= kmcl_pkg::RESET_LOCK_TWO_KEY;
        end else if (i_cfg_we) begin
            unique case (kmcl_pkg::t_cfg_index'(i_cfg_index))
                kmcl_pkg::CFG_LAYER_KEY:    r_layer_key    <= i_cfg_data;
                kmcl_pkg::CFG_LOCK_ONE_KEY: r_lock_one_key <= i_cfg_data;
                kmcl_pkg::CFG_LOCK_TWO_KEY: r_lock_two_key <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_lock_layer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_lock != kmcl_pkg::LOCK_TWO) || (r_layer == kmcl_pkg::LAYER_W'(2)))
        && ((r_lock != kmcl_pkg::LOCK_THREE) || (r_layer == kmcl_pkg::LAYER_W'(3))))
        else $error("layer lock and active layer disagree");
`endif

endmodule

// ===== src/kmcl_out_buf.sv =====
module kmcl_out_buf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push_en,
    input  kmcl_pkg::t_result i_result,
    output logic              o_full,
    kmcl_out_if.source        o_out
);

    kmcl_pkg::t_result r_main;
    kmcl_pkg::t_result n_main;
    kmcl_pkg::t_result r_skid;
    kmcl_pkg::t_result n_skid;
    logic              push;
    logic              pop;

    assign push = i_push_en && i_result.valid;
    assign pop  = r_main.valid && o_out.ready;

    always_comb begin
        n_main = r_main;
        n_skid = r_skid;
        if (pop) begin
            n_main       = r_skid;
            n_skid.valid = 1'b0;
        end
        if (push) begin
            if (!n_main.valid) begin
                n_main = i_result;
            end else begin
                n_skid = i_result;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main.valid <= 1'b0;
            r_skid.valid <= 1'b0;
        end else begin
            r_main <= n_main;
            r_skid <= n_skid;
        end
    end

    assign o_full          = r_skid.valid;
    assign o_out.valid     = r_main.valid;
    assign o_out.key_byte  = r_main.key_byte;
    assign o_out.key_index = r_main.key_index;
    assign o_out.pressed   = r_main.pressed;

`ifndef NO_ASSERTIONS
    a_skid_behind_main: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> r_main.valid)
        else $error("skid entry holds a result while the output slot is empty");
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid.valid |-> !push)
        else $error("result pushed into a full output buffer");
`endif

endmodule

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import kmcl_pkg::*;

    // One beat on the input channel: a column scan or a keymap load.
    typedef struct {
        t_op                   op;
        logic [COLUMN_W-1:0]   column;
        logic [ROW_BITS_W-1:0] row_bits;
        logic [MAP_ADDR_W-1:0] map_address;
        logic [CODE_W-1:0]     map_data;
    } t_matrix_beat;

    // One key event as it should leave the output channel.
    typedef struct {
        logic [CODE_W-1:0] key_byte;
        logic [KEY_W-1:0]  key_index;
        logic              pressed;
    } t_key_event;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    kmcl_in_if  scan_if ();
    kmcl_out_if key_if ();

    key_matrix_change_layer_mapper_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (scan_if),
        .o_out       (key_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Beats waiting to be driven, and key events waiting to be seen.
    t_matrix_beat beat_queue[$];
    t_key_event   expected_keys[$];

    // Shadow of the block: pressed-key map, layer state, keymap and registers.
    logic [MAP_KEYS-1:0] down_keys;
    logic [LAYER_W-1:0]  active_layer;
    t_lock               layer_lock;
    logic [CODE_W-1:0]   keymap_copy[KEYMAP_DEPTH];
    logic [KEY_W-1:0]    layer_key_cfg;
    logic [KEY_W-1:0]    lock_one_cfg;
    logic [KEY_W-1:0]    lock_two_cfg;

    // The stimulus side keeps its own view of which keys its scans hold down,
    // so that it can build scans that change exactly one key.
    logic [MAP_KEYS-1:0] planned_down;

    // Idle control shared by the driver and the output stall logic.
    int  idle_pct;
    bit  calm;
    int  in_gap;
    int  out_stall;
    bit  beat_taken;

    // Bookkeeping for the summary and the verdict.
    int  fault_count;
    int  loads_seen;
    int  scans_seen;
    int  results_checked;
    int  layer_updates;
    int  settings_used;

    function automatic bit key_is_down(input logic [KEY_W-1:0] k);
        return (k < MAP_KEYS) ? down_keys[k] : 1'b0;
    endfunction

    // A change of any layer key (base code bit 7 set) reevaluates the layer.
    // Holding the layer key gives layer one; with a lock key also held the
    // layer is locked at two or three and survives the layer key's release.
    task automatic update_layer_state();
        layer_updates++;
        if (key_is_down(layer_key_cfg)) begin
            active_layer = 2'd1;
            layer_lock   = LOCK_NONE;
            if (key_is_down(lock_one_cfg)) begin
                active_layer = 2'd2;
                layer_lock   = LOCK_TWO;
            end else if (key_is_down(lock_two_cfg)) begin
                active_layer = 2'd3;
                layer_lock   = LOCK_THREE;
            end
        end else if (layer_lock == LOCK_NONE) begin
            active_layer = 2'd0;
        end
    endtask

    // Works out what one accepted beat does to the shadow state, and queues
    // the key event it causes, if any.
    task automatic predict_key_change(input t_matrix_beat b);
        logic [63:0]           window_bits;
        logic [ROW_BITS_W-1:0] changed;
        int                    base;
        int                    key_no;
        logic [LAYER_W-1:0]    layer_sel;
        logic [CODE_W-1:0]     code;
        t_key_event            ev;
        if (b.op == OP_MAP_WRITE) begin
            keymap_copy[b.map_address] = b.map_data;
            return;
        end
        if (b.column >= COLUMN_COUNT) begin
            return;
        end
        base = b.column * ROWS_PER_COLUMN;
        if (base + ROWS_PER_COLUMN > MAP_KEYS) begin
            return;
        end
        window_bits = {1'b0, down_keys} >> base;
        changed = b.row_bits ^ window_bits[ROW_BITS_W-1:0];
        // Nothing changed, or more than one key changed: the scan is dropped.
        if (changed == '0 || (changed & (changed - 1'b1)) != '0) begin
            return;
        end
        key_no = base;
        for (int r = 0; r < ROW_BITS_W; r++) begin
            if (changed[r]) begin
                key_no = base + r;
            end
        end
        down_keys[key_no] = ~down_keys[key_no];
        if (keymap_copy[key_no][CODE_W-1]) begin
            update_layer_state();
            return;
        end
        // The layer field is two bits wide, so it never passes the top layer.
        layer_sel    = active_layer;
        code         = keymap_copy[{layer_sel, key_no[KEY_W-1:0]}];
        ev.pressed   = down_keys[key_no];
        ev.key_byte  = code + (ev.pressed ? 8'd128 : 8'd0);
        ev.key_index = key_no[KEY_W-1:0];
        expected_keys.push_back(ev);
    endtask

    function automatic bit is_cfg_key(input int k);
        return k == layer_key_cfg || k == lock_one_cfg || k == lock_two_cfg;
    endfunction

    function automatic void push_map_write(input logic [MAP_ADDR_W-1:0] addr,
                                           input logic [CODE_W-1:0] data);
        t_matrix_beat b;
        b.op          = OP_MAP_WRITE;
        b.column      = COLUMN_W'($urandom);
        b.row_bits    = ROW_BITS_W'($urandom);
        b.map_address = addr;
        b.map_data    = data;
        beat_queue.push_back(b);
    endfunction

    // Queues a scan and returns whether it changes exactly one key.
    function automatic bit push_scan(input int col, input logic [ROW_BITS_W-1:0] rows);
        t_matrix_beat          b;
        logic [ROW_BITS_W-1:0] changed;
        bit                    single;
        b.op          = OP_SCAN;
        b.column      = COLUMN_W'(col);
        b.row_bits    = rows;
        b.map_address = MAP_ADDR_W'($urandom);
        b.map_data    = CODE_W'($urandom);
        beat_queue.push_back(b);
        single = 1'b0;
        if (col < COLUMN_COUNT) begin
            changed = rows ^ planned_down[col*ROWS_PER_COLUMN +: ROWS_PER_COLUMN];
            single  = changed != '0 && (changed & (changed - 1'b1)) == '0;
            if (single) begin
                planned_down[col*ROWS_PER_COLUMN +: ROWS_PER_COLUMN] = rows;
            end
        end
        return single;
    endfunction

    // Base-layer codes with bit 7 set make the configured keys act as layer keys.
    function automatic void mark_layer_keys();
        logic [KEY_W-1:0] keys[3];
        keys[0] = layer_key_cfg;
        keys[1] = lock_one_cfg;
        keys[2] = lock_two_cfg;
        foreach (keys[i]) begin
            if (keys[i] < MAP_KEYS) begin
                push_map_write(MAP_ADDR_W'(keys[i]), 8'h80 | CODE_W'($urandom_range(127)));
            end
        end
    endfunction

    // Random traffic: mostly scans that change one key, some keymap loads,
    // and a share of scans the block must drop. Only loads and single-key
    // changes count toward the wanted number.
    task automatic add_random_beats(input int wanted);
        int                    made;
        int                    pick;
        int                    col;
        int                    key_no;
        int                    r1;
        int                    r2;
        logic [ROW_BITS_W-1:0] cur;
        logic [ROW_BITS_W-1:0] mask;
        logic [MAP_ADDR_W-1:0] addr;
        logic [CODE_W-1:0]     data;
        made = 0;
        while (made < wanted) begin
            pick = $urandom_range(99);
            col  = $urandom_range(COLUMN_COUNT - 1);
            cur  = planned_down[col*ROWS_PER_COLUMN +: ROWS_PER_COLUMN];
            if (pick < 8) begin
                addr = MAP_ADDR_W'($urandom);
                data = CODE_W'($urandom);
                if (addr < 64) begin
                    if (is_cfg_key(addr)) begin
                        data[CODE_W-1] = ($urandom_range(3) != 0);
                    end else begin
                        data[CODE_W-1] = ($urandom_range(9) == 0);
                    end
                end
                push_map_write(addr, data);
                made++;
            end else if (pick < 83) begin
                if ($urandom_range(4) == 0) begin
                    case ($urandom_range(2))
                        0: key_no = layer_key_cfg;
                        1: key_no = lock_one_cfg;
                        default: key_no = lock_two_cfg;
                    endcase
                    if (key_no >= MAP_KEYS) begin
                        key_no = $urandom_range(MAP_KEYS - 1);
                    end
                end else begin
                    key_no = $urandom_range(MAP_KEYS - 1);
                end
                col = key_no / ROWS_PER_COLUMN;
                cur = planned_down[col*ROWS_PER_COLUMN +: ROWS_PER_COLUMN];
                void'(push_scan(col, cur ^ (9'd1 << (key_no % ROWS_PER_COLUMN))));
                made++;
            end else if (pick < 90) begin
                r1   = $urandom_range(ROWS_PER_COLUMN - 1);
                r2   = (r1 + 1 + $urandom_range(ROWS_PER_COLUMN - 2)) % ROWS_PER_COLUMN;
                mask = (9'd1 << r1) | (9'd1 << r2)
                     | (ROW_BITS_W'($urandom) & ROW_BITS_W'($urandom));
                void'(push_scan(col, cur ^ mask));
            end else if (pick < 95) begin
                void'(push_scan(col, cur));
            end else begin
                void'(push_scan(COLUMN_COUNT, ROW_BITS_W'($urandom)));
            end
        end
    endtask

    // Registers change only while the block is idle, so the shadow copy is
    // updated right away.
    task automatic cfg_write(input t_cfg_index idx, input logic [KEY_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_LAYER_KEY:    layer_key_cfg = val;
            CFG_LOCK_ONE_KEY: lock_one_cfg  = val;
            default:          lock_two_cfg  = val;
        endcase
    endtask

    task automatic set_keys(input logic [KEY_W-1:0] lk, input logic [KEY_W-1:0] l1,
                            input logic [KEY_W-1:0] l2);
        cfg_write(CFG_LAYER_KEY, lk);
        cfg_write(CFG_LOCK_ONE_KEY, l1);
        cfg_write(CFG_LOCK_TWO_KEY, l2);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    // Holds the sender until every queued beat has gone in and every key
    // event has come out, then lets the last dropped scans drain through the
    // three-stage pipeline.
    task automatic wait_drained();
        int waited;
        waited = 0;
        while ((beat_queue.size() != 0 || scan_if.valid || expected_keys.size() != 0)
               && waited < 200000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (8) @(negedge i_clk);
    endtask

    // Monitor: at each rising edge an accepted input beat goes through the
    // shadow model, and an accepted output beat is checked against the
    // oldest key event still awaited.
    always @(posedge i_clk) begin
        t_matrix_beat b;
        t_key_event   want;
        if (i_rst_n) begin
            if (scan_if.valid && scan_if.ready) begin
                b.op          = t_op'(scan_if.op);
                b.column      = scan_if.column;
                b.row_bits    = scan_if.row_bits;
                b.map_address = scan_if.map_address;
                b.map_data    = scan_if.map_data;
                if (b.op == OP_MAP_WRITE) begin
                    loads_seen++;
                end else begin
                    scans_seen++;
                end
                predict_key_change(b);
                beat_taken = 1'b1;
            end
            if (key_if.valid && key_if.ready) begin
                if (expected_keys.size() == 0) begin
                    fault_count++;
                    if (fault_count <= 10) begin
                        $display("unexpected key beat: byte %02h index %0d pressed %0b",
                                 key_if.key_byte, key_if.key_index, key_if.pressed);
                    end
                end else begin
                    want = expected_keys.pop_front();
                    results_checked++;
                    if (key_if.key_byte !== want.key_byte
                        || key_if.key_index !== want.key_index
                        || key_if.pressed !== want.pressed) begin
                        fault_count++;
                        if (fault_count <= 10) begin
                            $display("key mismatch: want %02h/%0d/%0b got %02h/%0d/%0b",
                                     want.key_byte, want.key_index, want.pressed,
                                     key_if.key_byte, key_if.key_index, key_if.pressed);
                        end
                    end
                end
            end
        end
    end

    // Driver: at each falling edge the current beat is held until taken;
    // then either an idle burst starts or the next queued beat is put out.
    always @(negedge i_clk) begin
        t_matrix_beat b;
        if (i_rst_n && !(scan_if.valid && !beat_taken)) begin
            beat_taken = 1'b0;
            if (in_gap > 0) begin
                scan_if.valid <= 1'b0;
                in_gap--;
            end else if (beat_queue.size() == 0) begin
                scan_if.valid <= 1'b0;
            end else if (!calm && $urandom_range(99) < idle_pct) begin
                scan_if.valid <= 1'b0;
                in_gap = $urandom_range(1, 14) - 1;
            end else begin
                b = beat_queue.pop_front();
                scan_if.op          <= b.op;
                scan_if.column      <= b.column;
                scan_if.row_bits    <= b.row_bits;
                scan_if.map_address <= b.map_address;
                scan_if.map_data    <= b.map_data;
                scan_if.valid       <= 1'b1;
            end
        end
    end

    // The receiving side stalls in bursts of its own, independent of traffic.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!calm && out_stall > 0) begin
                key_if.ready <= 1'b0;
                out_stall--;
            end else if (!calm && $urandom_range(99) < idle_pct) begin
                key_if.ready <= 1'b0;
                out_stall = $urandom_range(1, 14) - 1;
            end else begin
                key_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        logic [CODE_W-1:0] data;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_LAYER_KEY;
        i_cfg_data          = '0;
        scan_if.valid       = 1'b0;
        scan_if.op          = OP_SCAN;
        scan_if.column      = '0;
        scan_if.row_bits    = '0;
        scan_if.map_address = '0;
        scan_if.map_data    = '0;
        key_if.ready        = 1'b0;

        down_keys     = '0;
        planned_down  = '0;
        active_layer  = '0;
        layer_lock    = LOCK_NONE;
        layer_key_cfg = RESET_LAYER_KEY;
        lock_one_cfg  = RESET_LOCK_ONE_KEY;
        lock_two_cfg  = RESET_LOCK_TWO_KEY;
        foreach (keymap_copy[i]) begin
            keymap_copy[i] = '0;
        end
        idle_pct        = 25;
        calm            = 1'b0;
        in_gap          = 0;
        out_stall       = 0;
        beat_taken      = 1'b0;
        fault_count     = 0;
        loads_seen      = 0;
        scans_seen      = 0;
        results_checked = 0;
        layer_updates   = 0;
        settings_used   = 1;

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Load the whole keymap first, so that no scan ever reads an entry
        // that was never written. Only the configured keys are layer keys at
        // the base layer to begin with.
        for (int a = 0; a < KEYMAP_DEPTH; a++) begin
            data = CODE_W'($urandom);
            if (a < 64) begin
                data[CODE_W-1] = is_cfg_key(a);
            end
            push_map_write(MAP_ADDR_W'(a), data);
        end

        // Directed part with the reset register values: extremes of the
        // fields, dropped scans, and a walk through every layer and both locks.
        push_map_write(8'hFF, 8'hFF);
        push_map_write(8'h00, 8'h00);
        void'(push_scan(0, 9'h000));   // no key changed
        void'(push_scan(0, 9'h001));   // first key down, code zero
        void'(push_scan(0, 9'h000));
        void'(push_scan(6, 9'h100));   // last key of the matrix
        void'(push_scan(6, 9'h000));
        void'(push_scan(7, 9'h1FF));   // column beyond the matrix
        void'(push_scan(3, 9'h1FF));   // several keys at once
        void'(push_scan(0, 9'h010));   // layer key held: layer one
        void'(push_scan(1, 9'h001));
        void'(push_scan(1, 9'h000));
        void'(push_scan(6, 9'h040));   // first lock key: layer two locked
        void'(push_scan(0, 9'h000));   // lock survives the layer key release
        void'(push_scan(1, 9'h001));
        void'(push_scan(1, 9'h000));
        void'(push_scan(6, 9'h000));
        void'(push_scan(0, 9'h010));   // layer key again clears the lock
        void'(push_scan(6, 9'h080));   // second lock key: layer three locked
        void'(push_scan(0, 9'h000));
        void'(push_scan(1, 9'h100));
        void'(push_scan(6, 9'h000));
        void'(push_scan(1, 9'h000));
        void'(push_scan(0, 9'h010));
        void'(push_scan(0, 9'h000));   // back to the base layer
        void'(push_scan(1, 9'h001));
        void'(push_scan(1, 9'h000));
        add_random_beats(260);
        wait_drained();

        // Extreme registers: key zero as the layer key, the last key as a
        // lock, and a lock naming the nonexistent key that never matches.
        idle_pct = 10;
        set_keys(6'd0, 6'd62, 6'd63);
        mark_layer_keys();
        add_random_beats(260);
        wait_drained();

        idle_pct = 45;
        set_keys(6'd62, 6'd0, 6'd31);
        mark_layer_keys();
        add_random_beats(260);
        wait_drained();

        idle_pct = 20;
        set_keys(6'($urandom_range(62)), 6'($urandom_range(62)), 6'($urandom_range(62)));
        mark_layer_keys();
        add_random_beats(260);
        wait_drained();

        // Last stretch runs at full rate on both sides.
        calm     = 1'b1;
        idle_pct = 0;
        set_keys(6'($urandom_range(62)), 6'($urandom_range(62)), 6'($urandom_range(62)));
        mark_layer_keys();
        add_random_beats(260);
        wait_drained();

        if (expected_keys.size() != 0) begin
            fault_count += expected_keys.size();
            $display("%0d key events never arrived", expected_keys.size());
        end
        $display("Drove %0d keymap loads and %0d column scans under %0d register settings.",
                 loads_seen, scans_seen, settings_used);
        $display("Checked %0d key beats; layer keys changed %0d times.",
                 results_checked, layer_updates);
        if (fault_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin
        #4ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule

// ===== key_matrix_change_layer_mapper_core.f =====
src/kmcl_pkg.sv
src/kmcl_in_if.sv
src/kmcl_out_if.sv
src/kmcl_ram.sv
src/kmcl_scan.sv
src/kmcl_layer.sv
src/kmcl_out_buf.sv
src/key_matrix_change_layer_mapper_core.sv
bench/testbench.sv
